// File: design/packet_buffer_pool_manager_assert.svh
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager_assert
// Concurrent assertion macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_POOL_MANAGER_ASSERT_SVH
`define PACKET_BUFFER_POOL_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define PBPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PBPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBPM_ASSERT(lbl, clk, rstn, prop, msg)
`define PBPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/pbpm_pkg.sv
// ----------------------------------------------------------------------------
// pbpm_pkg
// Component codes, operation kinds and status codes of the buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none
package pbpm_pkg;
  localparam logic [7:0] C_NULL      = 8'h00;
  localparam logic [7:0] C_OPENQUEUE = 8'h03;
  localparam logic [7:0] C_MAC       = 8'h09;
  localparam logic [7:0] C_TO_MAC    = 8'h0a;
  localparam logic [7:0] C_FROM_MAC  = 8'h0b;
  localparam logic [7:0] C_SIXTOP    = 8'h0c;
  localparam logic [7:0] C_RES       = 8'h0f;
  localparam logic [7:0] C_CEXAMPLE  = 8'h24;
  localparam logic [7:0] C_GROUPTRIG = 8'h30;

  localparam logic [1:0] T_NONE  = 2'd0;
  localparam logic [1:0] T_SHORT = 2'd1;
  localparam logic [1:0] T_LONG  = 2'd2;
  localparam logic [1:0] T_ANY   = 2'd3;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NONE = 3'd1, ST_NOSYNC = 3'd2,
    ST_FULL = 3'd3, ST_UNUSED = 3'd4, ST_BADIDX = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    K_ALLOC_FIRST = 4'd0, K_ALLOC_LAST = 4'd1, K_FREE = 4'd2,
    K_DROP_CREATOR = 4'd3, K_DROP_OWNER = 4'd4, K_SET = 4'd5,
    K_SENT = 4'd6, K_RECEIVED = 4'd7, K_COAP = 4'd8,
    K_MAC_DATA = 4'd9, K_BEACON = 4'd10
  } kind_e;

  // One slot record: owner, creator, hop type, low-power flag.
  typedef struct packed {
    logic [7:0] owner;
    logic [7:0] creator;
    logic [1:0] hop_type;
    logic       low_power;
  } slot_t;

  localparam int SlotW = $bits(slot_t);
endpackage
`default_nettype wire

// File: design/pbpm_ram.sv
// ----------------------------------------------------------------------------
// pbpm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pbpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/packet_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// packet_buffer_pool_manager
// Packet buffer slot pool: allocate, free, assign and priority searches.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: in_valid_i / in_stall_o with one port per field.
//    A request is taken when in_valid_i is high and in_stall_o is low.
//  - Result channel: out_valid_o / out_stall_i, one result per request,
//    held in an output register until taken.
//  - Config channel: cfg_valid_i / cfg_ready_o writes the high-priority
//    reserve; ready is always high, write only while idle.
//  - Slot records live in two synchronous RAMs (record, 64-bit address).
//    Sweeps read one slot per cycle through the single read port.
//    The next request is taken in the cycle after the result is registered.
//  - Reset: a clearing pass writes every record to its null state; no
//    request is taken during it.
//  - While the result waits under out_stall_i, the next request may be
//    accepted and processed; its result waits for the register to empty.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_buffer_pool_manager #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [3:0]  kind_i,
  input  wire  [7:0]  creator_id_i,
  input  wire  [7:0]  owner_id_i,
  input  wire  [3:0]  entry_index_i,
  input  wire  [1:0]  hop_type_i,
  input  wire  [63:0] hop_address_i,
  input  wire         low_power_i,
  input  wire         synchronized_i,
  input  wire         exclude_low_power_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [4:0]  cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        found_o,
  output logic [3:0]  result_index_o,
  output logic [2:0]  status_o
);
  import pbpm_pkg::*;
  `include "packet_buffer_pool_manager_assert.svh"

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;  // read issued at scan_q
  localparam logic [2:0] S_WRITE = 3'd3;  // final single-slot update
  localparam logic [2:0] S_DONE  = 3'd4;  // result waits for out register

  logic [2:0]      state_q, state_d;
  logic [IdxW:0]   scan_q, scan_d;      // issue counter, up to SLOT_COUNT
  logic            rd_vld_q, rd_vld_d;  // a read is in flight
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            pass_q, pass_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // latched request
  logic [3:0]  kind_q;
  logic [7:0]  cre_q, own_q;
  logic [3:0]  eidx_q;
  logic [1:0]  ht_q;
  logic [63:0] addr_q;
  logic        lp_q, sync_q, excl_q;

  logic            hit_q, hit_d;
  logic [IdxW-1:0] hidx_q, hidx_d;
  logic [CntW-1:0] lowcnt_q, lowcnt_d;
  logic            wasfree_q, wasfree_d;
  logic [2:0]      st_q, st_d;

  logic [4:0] reserve_q;

  logic            out_vld_q;
  logic            fnd_q;
  logic [3:0]      ridx_q;
  logic [2:0]      rst_q;

  // RAM ports
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wrec, rrec;
  slot_t           wrec_fix;
  logic            awe;
  logic [63:0]     raddr_data;

  pbpm_ram #(.Width(SlotW), .Depth(SLOT_COUNT)) u_rec_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wrec_fix),
    .raddr_i(raddr), .rdata_o(rrec)
  );
  pbpm_ram #(.Width(64), .Depth(SLOT_COUNT)) u_addr_ram (
    .clk_i, .we_i(awe), .waddr_i(waddr), .wdata_i(addr_q),
    .raddr_i(raddr), .rdata_o(raddr_data)
  );

  wire accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign found_o = fnd_q;
  assign result_index_o = ridx_q;
  assign status_o = rst_q;

  wire lowcre = (cre_q > C_RES);
  wire bad_idx = ({1'b0, eidx_q} >= 5'(SLOT_COUNT));

  // per-slot match terms on the read data
  logic is_bc, am, dest_ok, m;
  always_comb begin
    is_bc = (rrec.hop_type == T_SHORT && raddr_data[15:0] == 16'hffff) ||
            (rrec.hop_type == T_LONG && raddr_data == 64'hffff_ffff_ffff_ffff);
    am = (rrec.hop_type == T_LONG) && (raddr_data == addr_q);
    dest_ok = (ht_q == T_ANY) || (ht_q == T_LONG && am);
    m = 1'b0;
    case (kind_q)
      K_ALLOC_FIRST, K_ALLOC_LAST: m = (rrec.owner == C_NULL);
      K_DROP_CREATOR: m = (rrec.creator == cre_q);
      K_DROP_OWNER:   m = (rrec.owner == own_q);
      K_SENT:     m = rrec.owner == C_FROM_MAC && rrec.creator != C_MAC;
      K_RECEIVED: m = rrec.owner == C_FROM_MAC && rrec.creator == C_MAC;
      K_COAP:     m = rrec.creator == C_CEXAMPLE;
      K_BEACON:   m = rrec.owner == C_TO_MAC && rrec.creator == C_SIXTOP && is_bc;
      K_MAC_DATA: begin
        if (!pass_q) begin
          m = !(excl_q && rrec.low_power) && dest_ok &&
              ((rrec.owner == C_GROUPTRIG && rrec.creator == C_GROUPTRIG) ||
               (rrec.owner == C_TO_MAC && rrec.creator == C_RES));
        end else if (ht_q == T_LONG) begin
          m = rrec.owner == C_TO_MAC && !(excl_q && rrec.low_power) && am;
        end else begin
          m = rrec.owner == C_TO_MAC && (rrec.creator != C_SIXTOP || !is_bc);
        end
      end
      default: m = 1'b0;
    endcase
  end

  wire is_alloc = (kind_q == K_ALLOC_FIRST) || (kind_q == K_ALLOC_LAST);
  wire is_drop  = (kind_q == K_DROP_CREATOR) || (kind_q == K_DROP_OWNER);
  wire one_slot = (kind_q == K_FREE) || (kind_q == K_SET);
  wire scan_done = (scan_q == (IdxW+1)'(SLOT_COUNT));

  always_comb begin
    state_d = state_q; scan_d = scan_q; rd_vld_d = 1'b0; rd_idx_d = rd_idx_q;
    pass_d = pass_q; clr_d = clr_q; hit_d = hit_q; hidx_d = hidx_q;
    lowcnt_d = lowcnt_q; wasfree_d = wasfree_q; st_d = st_q;
    we = 1'b0; awe = 1'b0; waddr = rd_idx_q; wrec = rrec;
    raddr = scan_q[IdxW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q; wrec = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(SLOT_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN; scan_d = '0; pass_d = 1'b0;
          hit_d = 1'b0; hidx_d = '0; lowcnt_d = '0; wasfree_d = 1'b0;
        end
      end
      S_SCAN: begin
        // issue reads for the sweep (single-slot kinds read only their slot)
        if (one_slot) raddr = eidx_q[IdxW-1:0];
        else if (kind_q == K_ALLOC_LAST)
          raddr = IdxW'(SLOT_COUNT - 1) - scan_q[IdxW-1:0];
        if (!scan_done && !(one_slot && scan_q != '0)) begin
          rd_vld_d = 1'b1; rd_idx_d = raddr; scan_d = scan_q + 1'b1;
        end
        // evaluate the slot read in the previous cycle
        if (rd_vld_q) begin
          if (is_alloc && rrec.creator > C_RES) lowcnt_d = lowcnt_q + 1'b1;
          if (one_slot) wasfree_d = (rrec.owner == C_NULL);
          if (m && !hit_q) begin
            hit_d = 1'b1; hidx_d = rd_idx_q;
          end
          if (is_drop && m) begin
            we = 1'b1; wrec.owner = C_NULL; wrec.creator = C_NULL;
            wrec.hop_type = T_NONE;
          end
        end
        if (!rd_vld_q && (scan_done || (one_slot && scan_q != '0))) begin
          // sweep complete
          if (kind_q == K_MAC_DATA && !pass_q && !hit_q &&
              (ht_q == T_LONG || ht_q == T_ANY)) begin
            pass_d = 1'b1; scan_d = '0;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        state_d = S_DONE;
        st_d = hit_q ? ST_OK : ST_NONE;
        if (is_alloc) begin
          if (!sync_q && cre_q > C_MAC) begin
            st_d = ST_NOSYNC; hit_d = 1'b0;
          end else if (lowcre && (7'(lowcnt_q) + 7'(reserve_q) > 7'(SLOT_COUNT))) begin
            st_d = ST_FULL; hit_d = 1'b0;
          end else if (hit_q) begin
            we = 1'b1; waddr = hidx_q;
            wrec.owner = C_OPENQUEUE; wrec.creator = cre_q;
            wrec.hop_type = T_NONE; wrec.low_power = 1'b0;
            // hop type and low-power flag come back from keep_q below
          end
        end else if (one_slot) begin
          hit_d = 1'b0;
          if (bad_idx) st_d = ST_BADIDX;
          else begin
            hit_d = 1'b1; hidx_d = eidx_q[IdxW-1:0];
            we = 1'b1; waddr = eidx_q[IdxW-1:0];
            if (kind_q == K_FREE) begin
              st_d = wasfree_q ? ST_UNUSED : ST_OK;
              wrec.owner = C_NULL; wrec.creator = C_NULL; wrec.hop_type = T_NONE;
            end else begin
              st_d = ST_OK; awe = 1'b1;
              wrec.owner = own_q; wrec.hop_type = ht_q; wrec.low_power = lp_q;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Final update needs the untouched fields of the chosen slot; they are
  // captured from the read data when the slot is seen during the sweep.
  slot_t keep_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && rd_vld_q && m && !hit_q) keep_q <= rrec;
    if (one_slot && state_q == S_SCAN && rd_vld_q) keep_q <= rrec;
  end

  always_comb begin
    wrec_fix = wrec;
    if (state_q == S_WRITE) begin
      wrec_fix = keep_q;
      if (is_alloc) begin
        wrec_fix.owner = C_OPENQUEUE; wrec_fix.creator = cre_q;
      end else if (kind_q == K_FREE) begin
        wrec_fix.owner = C_NULL; wrec_fix.creator = C_NULL;
        wrec_fix.hop_type = T_NONE;
      end else begin
        wrec_fix.owner = own_q; wrec_fix.hop_type = ht_q;
        wrec_fix.low_power = lp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; scan_q <= '0; rd_vld_q <= 1'b0; pass_q <= 1'b0;
      clr_q <= '0; hit_q <= 1'b0; lowcnt_q <= '0; reserve_q <= 5'd5;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d; scan_q <= scan_d; rd_vld_q <= rd_vld_d;
      pass_q <= pass_d; clr_q <= clr_d; hit_q <= hit_d; lowcnt_q <= lowcnt_d;
      if (cfg_valid_i) reserve_q <= cfg_data_i;
      if (state_q == S_DONE && (!out_vld_q || !out_stall_i)) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d; hidx_q <= hidx_d; wasfree_q <= wasfree_d; st_q <= st_d;
    if (accept) begin
      kind_q <= kind_i; cre_q <= creator_id_i; own_q <= owner_id_i;
      eidx_q <= entry_index_i; ht_q <= hop_type_i; addr_q <= hop_address_i;
      lp_q <= low_power_i; sync_q <= synchronized_i;
      excl_q <= exclude_low_power_i;
    end
    if (state_q == S_DONE && (!out_vld_q || !out_stall_i)) begin
      fnd_q <= hit_q; ridx_q <= hit_q ? 4'(hidx_q) : 4'd0; rst_q <= st_q;
    end
  end

  `PBPM_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall_o, "busy not stalled")
  `PBPM_ASSERT(a_out_hold, clk_i, rst_ni, (out_vld_q && out_stall_i) |=> out_vld_q, "result dropped")
  `PBPM_ASSERT(a_ok_found, clk_i, rst_ni, (out_vld_q && rst_q == ST_OK) |-> fnd_q, "ok without hit")
endmodule
`default_nettype wire

// File: tb/sv/tb_packet_buffer_pool_manager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_buffer_pool_manager
// Self-checking bench for the buffer pool: a slot-level predictor in a small
// scoreboard class follows every request and checks each result in order,
// under random idling on both channels and several reserve settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_packet_buffer_pool_manager;
  import pbpm_pkg::*;

  localparam int NSLOT      = 16;
  localparam int PHASE_REQS = 300;
  localparam int CYCLE_CAP  = 1000000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  creator;
    logic [7:0]  owner;
    logic [3:0]  idx;
    logic [1:0]  ht;
    logic [63:0] addr;
    logic        lp;
    logic        sync;
    logic        excl;
  } pool_req_t;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
    status_e    status;
  } pool_rsp_t;

  // Slot-level model of the pool plus the queue of pending responses.
  class pool_scoreboard;
    logic [7:0]  own [NSLOT];
    logic [7:0]  cre [NSLOT];
    logic [1:0]  hty [NSLOT];
    logic [63:0] adr [NSLOT];
    logic        lpw [NSLOT];
    int          reserve;
    int          errors;
    pool_rsp_t   pending_rsp[$];

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        own[i] = C_NULL; cre[i] = C_NULL; hty[i] = T_NONE;
        adr[i] = '0; lpw[i] = 1'b0;
      end
      reserve = 5;
      errors  = 0;
    endfunction

    function void clear(int i);
      own[i] = C_NULL; cre[i] = C_NULL; hty[i] = T_NONE;
    endfunction

    function bit bcast(int i);
      if (hty[i] == T_SHORT) return adr[i][15:0] == 16'hffff;
      if (hty[i] == T_LONG)  return &adr[i];
      return 1'b0;
    endfunction

    function bit addr_hit(int i, logic [63:0] a);
      return hty[i] == T_LONG && adr[i] == a;
    endfunction

    function int mac_pick(logic [1:0] ht, logic [63:0] a, bit excl);
      // first pass: group-trigger and reserved sixtop traffic
      for (int i = 0; i < NSLOT; i++) begin
        if (excl && lpw[i]) continue;
        if (!(ht == T_ANY || (ht == T_LONG && addr_hit(i, a)))) continue;
        if (own[i] == C_GROUPTRIG && cre[i] == C_GROUPTRIG) return i;
        if (own[i] == C_TO_MAC && cre[i] == C_RES) return i;
      end
      if (ht == T_LONG) begin
        for (int i = 0; i < NSLOT; i++)
          if (own[i] == C_TO_MAC && !(excl && lpw[i]) && addr_hit(i, a)) return i;
      end else if (ht == T_ANY) begin
        for (int i = 0; i < NSLOT; i++)
          if (own[i] == C_TO_MAC && (cre[i] != C_SIXTOP || !bcast(i))) return i;
      end
      return -1;
    endfunction

    function int alloc(pool_req_t r, output status_e st);
      int n;
      n = 0;
      if (!r.sync && r.creator > C_MAC) begin
        st = ST_NOSYNC; return -1;
      end
      for (int i = 0; i < NSLOT; i++) if (cre[i] > C_RES) n++;
      if (r.creator > C_RES && n + reserve > NSLOT) begin
        st = ST_FULL; return -1;
      end
      for (int i = 0; i < NSLOT; i++) begin
        int k;
        k = (r.kind == K_ALLOC_LAST) ? NSLOT - 1 - i : i;
        if (own[k] == C_NULL) begin
          cre[k] = r.creator; own[k] = C_OPENQUEUE; st = ST_OK; return k;
        end
      end
      st = ST_NONE;
      return -1;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(pool_req_t r);
      int        hit;
      status_e   st;
      pool_rsp_t rsp;
      bit        m;
      hit = -1;
      st  = ST_NONE;
      case (r.kind)
        K_ALLOC_FIRST, K_ALLOC_LAST: hit = alloc(r, st);
        K_FREE: begin
          st = (own[r.idx] == C_NULL) ? ST_UNUSED : ST_OK;
          clear(r.idx);
          hit = r.idx;
        end
        K_DROP_CREATOR, K_DROP_OWNER: begin
          for (int i = 0; i < NSLOT; i++) begin
            m = (r.kind == K_DROP_CREATOR) ? cre[i] == r.creator : own[i] == r.owner;
            if (m) begin
              clear(i);
              if (hit < 0) hit = i;
            end
          end
          st = (hit >= 0) ? ST_OK : ST_NONE;
        end
        K_SET: begin
          own[r.idx] = r.owner; hty[r.idx] = r.ht;
          adr[r.idx] = r.addr;  lpw[r.idx] = r.lp;
          hit = r.idx; st = ST_OK;
        end
        K_SENT, K_RECEIVED, K_COAP, K_BEACON: begin
          for (int i = 0; i < NSLOT && hit < 0; i++) begin
            case (r.kind)
              K_SENT:     m = own[i] == C_FROM_MAC && cre[i] != C_MAC;
              K_RECEIVED: m = own[i] == C_FROM_MAC && cre[i] == C_MAC;
              K_COAP:     m = cre[i] == C_CEXAMPLE;
              default:    m = own[i] == C_TO_MAC && cre[i] == C_SIXTOP && bcast(i);
            endcase
            if (m) hit = i;
          end
          st = (hit >= 0) ? ST_OK : ST_NONE;
        end
        K_MAC_DATA: begin
          hit = mac_pick(r.ht, r.addr, r.excl);
          st  = (hit >= 0) ? ST_OK : ST_NONE;
        end
        default: st = ST_NONE;
      endcase
      rsp.found  = hit >= 0;
      rsp.index  = (hit >= 0) ? hit[3:0] : 4'd0;
      rsp.status = st;
      pending_rsp.push_back(rsp);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_response(pool_rsp_t got);
      pool_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("unexpected response", 8'(got.status), 8'd0);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.found !== want.found) report("found", 8'(got.found), 8'(want.found));
      if (got.index !== want.index) report("result_index", 8'(got.index), 8'(want.index));
      if (got.status !== want.status) report("status", 8'(got.status), 8'(want.status));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  kind_i = '0;
  logic [7:0]  creator_id_i = '0;
  logic [7:0]  owner_id_i = '0;
  logic [3:0]  entry_index_i = '0;
  logic [1:0]  hop_type_i = '0;
  logic [63:0] hop_address_i = '0;
  logic        low_power_i = 1'b0;
  logic        synchronized_i = 1'b0;
  logic        exclude_low_power_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        found_o;
  logic [3:0]  result_index_o;
  logic [2:0]  status_o;

  pool_scoreboard sb = new();
  bit  quiet;       // no idling on either side
  bit  hold_req;    // ask the receiver for one long hold-off
  int  cycles;
  logic [63:0] addr_pool [4] = '{64'h1122_3344_5566_7788, 64'h0123_4567_89ab_cdef,
                                 '1, 64'h0000_0000_0000_ffff};

  packet_buffer_pool_manager #(.SLOT_COUNT(NSLOT)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .creator_id_i,
    .owner_id_i, .entry_index_i, .hop_type_i, .hop_address_i, .low_power_i,
    .synchronized_i, .exclude_low_power_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .out_valid_o, .out_stall_i, .found_o, .result_index_o,
    .status_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response monitor: sample at the edge, before any of this step's updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_response('{found_o, result_index_o, status_e'(status_o)});
  end

  // Receiver: random stall bursts, plus one long hold to back up the pool.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until taken; maybe idle afterwards.
  task send_request(pool_req_t r);
    kind_i <= r.kind;       creator_id_i <= r.creator; owner_id_i <= r.owner;
    entry_index_i <= r.idx; hop_type_i <= r.ht;        hop_address_i <= r.addr;
    low_power_i <= r.lp;    synchronized_i <= r.sync;  exclude_low_power_i <= r.excl;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Reserve write, only once the pool has drained.
  task write_reserve(logic [4:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_rsp.size() != 0);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.reserve = v;
  endtask

  function logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0: return C_NULL;       1: return C_OPENQUEUE; 2: return C_MAC;
      3: return C_TO_MAC;     4: return C_FROM_MAC;  5: return C_SIXTOP;
      6: return C_RES;        7: return C_CEXAMPLE;  8, 9: return C_GROUPTRIG;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [63:0] pick_addr();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return addr_pool[$urandom_range(0, 3)];
  endfunction

  function pool_req_t random_request();
    pool_req_t r;
    int w;
    r.creator = pick_code(); r.owner = pick_code();
    r.idx = 4'($urandom);    r.ht = 2'($urandom);
    r.addr = pick_addr();    r.lp = 1'($urandom);
    r.sync = $urandom_range(0, 4) != 0;
    r.excl = 1'($urandom);
    w = $urandom_range(0, 99);
    if (w < 24)      r.kind = $urandom_range(0, 1) ? K_ALLOC_LAST : K_ALLOC_FIRST;
    else if (w < 48) r.kind = K_SET;
    else if (w < 58) r.kind = K_FREE;
    else if (w < 61) r.kind = K_DROP_CREATOR;
    else if (w < 64) r.kind = K_DROP_OWNER;
    else if (w < 95) r.kind = 4'($urandom_range(K_SENT, K_BEACON));
    else             r.kind = 4'($urandom_range(11, 15));
    return r;
  endfunction

  function pool_req_t make_req(kind_e k, logic [7:0] c, logic [7:0] o, int idx,
                               logic [1:0] ht, logic [63:0] a, bit sync);
    pool_req_t r;
    r = '{kind: k, creator: c, owner: o, idx: 4'(idx), ht: ht, addr: a,
          lp: 1'b0, sync: sync, excl: 1'b0};
    return r;
  endfunction

  int reserves [6] = '{16, 0, 31, 3, 17, 5};

  initial begin
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: give every slot a written address first (slots stay free).
    for (int i = 0; i < NSLOT; i++)
      send_request(make_req(K_SET, C_NULL, C_NULL, i, T_NONE,
                            (i == 0) ? 64'd0 : {$urandom, $urandom}, 1'b1));
    send_request(make_req(K_ALLOC_FIRST, C_CEXAMPLE, C_NULL, 0, T_NONE, 0, 1'b0));
    send_request(make_req(K_ALLOC_FIRST, C_MAC, C_NULL, 0, T_NONE, 0, 1'b0));
    send_request(make_req(K_ALLOC_LAST, C_GROUPTRIG, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_SET, C_NULL, C_GROUPTRIG, 15, T_LONG, addr_pool[0], 1'b1));
    send_request(make_req(K_MAC_DATA, C_NULL, C_NULL, 0, T_LONG, addr_pool[0], 1'b1));
    send_request(make_req(K_MAC_DATA, C_NULL, C_NULL, 0, T_SHORT, addr_pool[0], 1'b1));
    send_request(make_req(K_SET, C_NULL, C_TO_MAC, 0, T_LONG, '1, 1'b1));
    send_request(make_req(K_MAC_DATA, C_NULL, C_NULL, 0, T_ANY, '1, 1'b1));
    send_request(make_req(K_BEACON, C_NULL, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_FREE, C_NULL, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_FREE, C_NULL, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_COAP, C_NULL, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_DROP_OWNER, C_NULL, C_GROUPTRIG, 0, T_NONE, 0, 1'b1));
    send_request(make_req(K_DROP_CREATOR, C_CEXAMPLE, C_NULL, 0, T_NONE, 0, 1'b1));
    send_request(make_req(kind_e'(4'd15), C_NULL, C_NULL, 0, T_NONE, 0, 1'b1));

    // Random phases under several reserve settings; last one runs without gaps.
    foreach (reserves[p]) begin
      write_reserve(5'(reserves[p]));
      if (p == 1) hold_req = 1'b1;
      if (p == 5) quiet = 1'b1;
      repeat (PHASE_REQS) send_request(random_request());
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.pending_rsp.size() != 0);
    repeat (2 * NSLOT + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
